FILE: hw/rtl/spm_pkg.sv
// Package for the I2C slave pointer memory: bus event codes and
// write-sequence byte counter codes. No dependencies.
package spm_pkg;

   localparam int OP_W = 3;
   localparam int CNT_W = 2;

   // Bus event codes carried on req_op.
   localparam logic [OP_W-1:0] EV_ADDR_W  = 3'd0;
   localparam logic [OP_W-1:0] EV_RX_ACK  = 3'd1;
   localparam logic [OP_W-1:0] EV_ADDR_R  = 3'd2;
   localparam logic [OP_W-1:0] EV_TX_NACK = 3'd3;
   localparam logic [OP_W-1:0] EV_RX_NACK = 3'd4;
   localparam logic [OP_W-1:0] EV_STOP    = 3'd5;

   // Position in the write sequence.
   localparam logic [CNT_W-1:0] CNT_HIGH = 2'd0;
   localparam logic [CNT_W-1:0] CNT_LOW  = 2'd1;
   localparam logic [CNT_W-1:0] CNT_DATA = 2'd2;

endpackage

FILE: hw/rtl/i2c_slave_pointer_memory.sv
// Slave-side I2C byte memory with a two-byte address pointer.
// Depends on spm_pkg for event and byte counter codes.
//
// Usage: one bus event is one transaction. It is taken on the rising edge where
// start is high and busy is low, with req_op naming the event and req_rx_byte
// the byte received with it. Exactly one result follows per transaction: on the
// next cycle rsp_valid is high for a single cycle together with rsp_tx_valid,
// rsp_tx_byte, rsp_write_done and rsp_unhandled. A new event can be taken every
// cycle while busy is low; the pointer, counter and memory are updated
// at the accepting edge and the memory read data register feeds rsp_tx_byte.
// The memory has one write and one read port, each used at most once per event.
// After reset the memory is cleared by a sweep over all 2**ADDR_BITS entries,
// one entry per cycle, during which busy stays high; the pointer, high address
// byte and byte counter clear at once. The receiver cannot stall: each result
// is presented for one cycle only and is then gone.
module i2c_slave_pointer_memory
   import spm_pkg::*;
#(
   parameter int ADDR_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_op,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   output logic              rsp_tx_valid,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_write_done,
   output logic              rsp_unhandled
);

   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   logic [7:0] mem [MEM_DEPTH];

   logic                 clear_ff;
   logic                 clear_in;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [ADDR_BITS-1:0] clr_addr_in;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [7:0]           high_ff;
   logic [7:0]           high_in;
   logic [ADDR_BITS-1:0] ptr_ff;
   logic [ADDR_BITS-1:0] ptr_in;

   logic                 valid_ff;
   logic                 tx_valid_ff;
   logic                 tx_valid_in;
   logic                 write_done_ff;
   logic                 write_done_in;
   logic                 unhandled_ff;
   logic                 unhandled_in;
   logic [7:0]           rdata_ff;

   logic                 accept;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [7:0]           wr_data;
   logic [15:0]          full_addr;

   assign busy   = clear_ff;
   assign accept = start && !clear_ff;
   assign full_addr = {high_ff, req_rx_byte};

   always_comb begin
      count_in      = count_ff;
      high_in       = high_ff;
      ptr_in        = ptr_ff;
      tx_valid_in   = 1'b0;
      write_done_in = 1'b0;
      unhandled_in  = 1'b0;
      if (accept) begin
         unique case (req_op)
            EV_ADDR_W: count_in = CNT_HIGH;
            EV_RX_ACK: begin
               unique case (count_ff)
                  CNT_LOW: begin
                     ptr_in   = full_addr[ADDR_BITS-1:0];
                     count_in = CNT_DATA;
                  end
                  CNT_DATA: begin
                     write_done_in = 1'b1;
                     count_in      = CNT_HIGH;
                  end
                  // The unused counter value behaves like the high byte position.
                  default: begin
                     high_in  = req_rx_byte;
                     count_in = CNT_LOW;
                  end
               endcase
            end
            EV_ADDR_R: begin
               tx_valid_in = 1'b1;
               ptr_in      = ptr_ff + 1'b1;
            end
            EV_TX_NACK: ;
            EV_RX_NACK, EV_STOP: count_in = CNT_HIGH;
            default: unhandled_in = 1'b1;
         endcase
      end
   end

   // The clearing sweep owns the write port until it ends.
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clear_in = 1'b0;
         end
      end
      wr_en   = clear_ff || write_done_in;
      wr_addr = clear_ff ? clr_addr_ff : ptr_ff;
      wr_data = clear_ff ? 8'd0 : req_rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clr_addr_ff   <= '0;
         count_ff      <= CNT_HIGH;
         high_ff       <= 8'd0;
         ptr_ff        <= '0;
         valid_ff      <= 1'b0;
         tx_valid_ff   <= 1'b0;
         write_done_ff <= 1'b0;
         unhandled_ff  <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clr_addr_ff   <= clr_addr_in;
         count_ff      <= count_in;
         high_ff       <= high_in;
         ptr_ff        <= ptr_in;
         valid_ff      <= accept;
         tx_valid_ff   <= tx_valid_in;
         write_done_ff <= write_done_in;
         unhandled_ff  <= unhandled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (tx_valid_in) begin
         rdata_ff <= mem[ptr_ff];
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_tx_valid   = tx_valid_ff;
   assign rsp_tx_byte    = tx_valid_ff ? rdata_ff : 8'd0;
   assign rsp_write_done = write_done_ff;
   assign rsp_unhandled  = unhandled_ff;

   // A result appears only in the cycle after an accepted transaction.
   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result without an accepted transaction");

   // At most one kind of result flag is raised for one event.
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      $countones({rsp_tx_valid, rsp_write_done, rsp_unhandled}) <= 1)
      else $error("more than one result flag raised");

   // A store is only reported from the data byte position and restarts the count.
   a_write_from_data: assert property (@(posedge clock) disable iff (reset)
      rsp_write_done |-> ($past(count_ff) == CNT_DATA && count_ff == CNT_HIGH))
      else $error("write reported outside the data byte position");

   // Flags never show without the strobe.
   a_flags_need_strobe: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !(rsp_tx_valid || rsp_write_done || rsp_unhandled))
      else $error("result flag without strobe");

endmodule

FILE: sim/tb_top.sv
// Testbench for i2c_slave_pointer_memory: drives bus events with bursty timing and checks
// every result against a directed expectation or a behavioral model of the byte memory and pointer.
// Depends on spm_pkg and the i2c_slave_pointer_memory RTL.
module tb_top
   import spm_pkg::*;
();

   localparam int ADDR_BITS = 8;
   localparam int MEM_SIZE = 1 << ADDR_BITS;
   localparam int RANDOM_ITEMS = 1550;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;

   // Event codes the block does not process.
   localparam logic [OP_W-1:0] EV_OTHER    = 3'd6;
   localparam logic [OP_W-1:0] EV_RESERVED = 3'd7;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       write_done;
      logic       unhandled;
   } spm_result_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [7:0]      rx;
      logic            typed;
      spm_result_type  want;
   } stim_row_type;

   localparam spm_result_type RSP_QUIET     = '{1'b0, 8'h00, 1'b0, 1'b0};
   localparam spm_result_type RSP_UNHANDLED = '{1'b0, 8'h00, 1'b0, 1'b1};
   localparam spm_result_type RSP_STORED    = '{1'b0, 8'h00, 1'b1, 1'b0};
   localparam spm_result_type RSP_READ_ZERO = '{1'b1, 8'h00, 1'b0, 1'b0};

   // Rows with typed = 0 are checked against the model instead.
   localparam stim_row_type DIRECTED [24] = '{
      '{EV_ADDR_R,   8'h00, 1'b1, RSP_READ_ZERO},  // memory is clear after reset
      '{EV_OTHER,    8'hA5, 1'b1, RSP_UNHANDLED},
      '{EV_RESERVED, 8'h5A, 1'b1, RSP_UNHANDLED},
      '{EV_TX_NACK,  8'hFF, 1'b1, RSP_QUIET},
      '{EV_ADDR_W,   8'h00, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'hFF, 1'b1, RSP_QUIET},      // high byte is truncated away
      '{EV_RX_ACK,   8'hFF, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'hFF, 1'b1, RSP_STORED},
      '{EV_ADDR_R,   8'h00, 1'b0, RSP_QUIET},      // top entry, pointer wraps to zero
      '{EV_ADDR_R,   8'h00, 1'b0, RSP_QUIET},
      '{EV_ADDR_W,   8'h00, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'h00, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'h01, 1'b1, RSP_QUIET},
      '{EV_STOP,     8'h00, 1'b1, RSP_QUIET},      // stop before the data byte
      '{EV_RX_ACK,   8'h80, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'h7F, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'h00, 1'b1, RSP_STORED},
      '{EV_RX_ACK,   8'h12, 1'b1, RSP_QUIET},
      '{EV_RX_NACK,  8'h00, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'h33, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'h80, 1'b1, RSP_QUIET},
      '{EV_RX_ACK,   8'hC3, 1'b1, RSP_STORED},
      '{EV_ADDR_R,   8'h00, 1'b0, RSP_QUIET},      // a write leaves the pointer in place
      '{EV_ADDR_R,   8'h00, 1'b0, RSP_QUIET}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   logic [OP_W-1:0] req_op = '0;
   logic [7:0]      req_rx_byte = '0;
   logic            rsp_valid;
   logic            rsp_tx_valid;
   logic [7:0]      rsp_tx_byte;
   logic            rsp_write_done;
   logic            rsp_unhandled;

   // Model state of the emulated memory.
   logic [CNT_W-1:0]     model_count = CNT_HIGH;
   logic [7:0]           model_high = '0;
   logic [ADDR_BITS-1:0] model_ptr = '0;
   bit   [7:0]           model_mem [MEM_SIZE];

   stim_row_type   bus_events [$];
   spm_result_type pending_rsp [$];
   int             mismatch_count = 0;
   int             stall_cycles = 0;

   i2c_slave_pointer_memory #(.ADDR_BITS(ADDR_BITS)) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_write_done (rsp_write_done),
      .rsp_unhandled  (rsp_unhandled)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic emulate_eeprom(input logic [OP_W-1:0] op, input logic [7:0] rx,
                                 output spm_result_type r);
      logic [15:0] full_addr;
      r = RSP_QUIET;
      case (op)
         EV_ADDR_W: model_count = CNT_HIGH;
         EV_RX_ACK: begin
            if (model_count == CNT_LOW) begin
               full_addr = {model_high, rx};
               model_ptr = full_addr[ADDR_BITS-1:0];
               model_count = CNT_DATA;
            end else if (model_count == CNT_DATA) begin
               model_mem[model_ptr] = rx;
               r.write_done = 1'b1;
               model_count = CNT_HIGH;
            end else begin
               model_high = rx;
               model_count = CNT_LOW;
            end
         end
         EV_ADDR_R: begin
            r.tx_valid = 1'b1;
            r.tx_byte = model_mem[model_ptr];
            model_ptr = model_ptr + 1'b1;
         end
         EV_TX_NACK: ;
         EV_RX_NACK, EV_STOP: model_count = CNT_HIGH;
         default: r.unhandled = 1'b1;
      endcase
   endtask

   function automatic void queue_item(input logic [OP_W-1:0] op, input logic [7:0] rx);
      bus_events.push_back(stim_row_type'{op, rx, 1'b0, RSP_QUIET});
   endfunction

   // Low address bytes lean toward two small windows so that reads find written data.
   function automatic logic [7:0] pick_low_addr();
      case ($urandom_range(0, 3))
         0, 1: return 8'($urandom_range(0, 15));
         2: return 8'($urandom_range(250, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic report(input string field, input int exp_val, input int act_val);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, exp_val,
               act_val);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      spm_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h/%0h",
                     $realtime, rsp_tx_valid, rsp_tx_byte, rsp_write_done, rsp_unhandled);
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tx_valid !== want.tx_valid)
               report("tx_valid", want.tx_valid, rsp_tx_valid);
            if (rsp_tx_byte !== want.tx_byte)
               report("tx_byte", want.tx_byte, rsp_tx_byte);
            if (rsp_write_done !== want.write_done)
               report("write_done", want.write_done, rsp_write_done);
            if (rsp_unhandled !== want.unhandled)
               report("unhandled", want.unhandled, rsp_unhandled);
         end
      end
   end

   // Ends the run when neither a bus event nor a result moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("[i2c_slave_pointer_memory] ERROR");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type   row;
      spm_result_type predicted;
      int             burst_left;
      int             gap;
      int             n;

      foreach (DIRECTED[i])
         bus_events.push_back(DIRECTED[i]);

      while (bus_events.size() < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // Write transaction, now and then cut short.
               n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 2) : 3;
               queue_item(EV_ADDR_W, 8'($urandom));
               queue_item(EV_RX_ACK, 8'($urandom));
               if (n > 1) queue_item(EV_RX_ACK, pick_low_addr());
               if (n > 2) queue_item(EV_RX_ACK, 8'($urandom));
               queue_item(($urandom_range(0, 4) == 0) ? EV_RX_NACK : EV_STOP, 8'($urandom));
            end
            4, 5, 6: begin
               // Random read: set the pointer, stop, then read bytes.
               queue_item(EV_ADDR_W, 8'($urandom));
               queue_item(EV_RX_ACK, 8'($urandom));
               queue_item(EV_RX_ACK, pick_low_addr());
               queue_item(EV_STOP, 8'($urandom));
               n = $urandom_range(1, 4);
               repeat (n) queue_item(EV_ADDR_R, 8'($urandom));
               queue_item(EV_TX_NACK, 8'($urandom));
               queue_item(EV_STOP, 8'($urandom));
            end
            7: begin
               // Read from the current address.
               n = $urandom_range(1, 3);
               repeat (n) queue_item(EV_ADDR_R, 8'($urandom));
               queue_item(EV_TX_NACK, 8'($urandom));
               queue_item(EV_STOP, 8'($urandom));
            end
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) queue_item(OP_W'($urandom_range(0, 7)), 8'($urandom));
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      burst_left = 0;
      while (bus_events.size() != 0) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 16);
         end
         row = bus_events.pop_front();
         start <= 1'b1;
         req_op <= row.op;
         req_rx_byte <= row.rx;
         do @(posedge clock); while (busy);
         emulate_eeprom(row.op, row.rx, predicted);
         pending_rsp.push_back(row.typed ? row.want : predicted);
         burst_left--;
      end
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[i2c_slave_pointer_memory] OK");
      else
         $display("[i2c_slave_pointer_memory] ERROR");
      $finish;
   end

endmodule
